### rtl/lfu_pkg.sv
// Shared constants, types and state codes for the LFU cache policy unit.
package lfu_pkg;

   // Slot count and use counter width
   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;

   // Derived widths
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CAP_W  = 5;
   localparam int CAPE_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP,
      ST_UPD
   } state_type;

   // What the update pass does
   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } upd_mode_type;

   // Registered slot read word
   typedef struct packed {
      logic                  vld;
      logic [IDX_W-1:0]      idx;
      logic                  valid;
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_W-1:0]      rank;
   } slot_rd_type;

   // Slot write command
   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      idx;
      logic                  valid;
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_W-1:0]      rank;
   } slot_wr_type;

   // Scan findings: key match, eviction candidate, first free slot
   typedef struct packed {
      logic                  hit;
      logic [IDX_W-1:0]      hit_idx;
      logic [VAL_W-1:0]      hit_value;
      logic [IDX_W-1:0]      hit_rank;
      logic                  vic_found;
      logic [IDX_W-1:0]      vic_idx;
      logic [COUNT_BITS-1:0] vic_count;
      logic [IDX_W-1:0]      vic_rank;
      logic                  free_found;
      logic [IDX_W-1:0]      free_idx;
   } scan_res_type;

endpackage

### rtl/lfu_slot_store.sv
// Slot storage: valid flops plus key, value, count and rank arrays, one registered read port.
module lfu_slot_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [lfu_pkg::IDX_W-1:0] rd_idx,
   input  lfu_pkg::slot_wr_type wr,
   output lfu_pkg::slot_rd_type rd
);
   import lfu_pkg::*;

   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_W-1:0]      key_mem   [ENTRIES];
   logic [VAL_W-1:0]      value_mem [ENTRIES];
   logic [COUNT_BITS-1:0] count_mem [ENTRIES];
   logic [IDX_W-1:0]      rank_mem  [ENTRIES];
   slot_rd_type           rd_ff;

   // Valid bits: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= wr.valid;
      end
   end

   // Payload arrays: written only, no reset
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.idx]   <= wr.key;
         value_mem[wr.idx] <= wr.value;
         count_mem[wr.idx] <= wr.count;
         rank_mem[wr.idx]  <= wr.rank;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff.vld <= 1'b0;
      end else begin
         rd_ff.vld <= rd_en;
      end
      rd_ff.idx   <= rd_idx;
      rd_ff.valid <= valid_ff[rd_idx];
      rd_ff.key   <= key_mem[rd_idx];
      rd_ff.value <= value_mem[rd_idx];
      rd_ff.count <= count_mem[rd_idx];
      rd_ff.rank  <= rank_mem[rd_idx];
   end

   assign rd = rd_ff;

endmodule

### rtl/lfu_scan_unit.sv
// Shared compare unit: one slot per cycle against the key and the running (count, rank) minimum.
module lfu_scan_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clr,
   input  logic                        en,
   input  logic [lfu_pkg::KEY_W-1:0]   key,
   input  lfu_pkg::slot_rd_type        rd,
   output lfu_pkg::scan_res_type       res
);
   import lfu_pkg::*;

   scan_res_type res_ff;
   scan_res_type res_in;
   logic         key_eq;
   logic         lower;

   // One key compare and one (count, rank) compare
   assign key_eq = rd.valid && (rd.key == key);
   assign lower  = rd.valid && (!res_ff.vic_found || (rd.count < res_ff.vic_count) ||
                   ((rd.count == res_ff.vic_count) && (rd.rank < res_ff.vic_rank)));

   // Accumulate findings; first match and first free slot win
   always_comb begin
      res_in = res_ff;
      if (clr) begin
         res_in.hit        = 1'b0;
         res_in.vic_found  = 1'b0;
         res_in.free_found = 1'b0;
      end else if (en && rd.vld) begin
         if (key_eq && !res_ff.hit) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = rd.idx;
            res_in.hit_value = rd.value;
            res_in.hit_rank  = rd.rank;
         end
         if (lower) begin
            res_in.vic_found = 1'b1;
            res_in.vic_idx   = rd.idx;
            res_in.vic_count = rd.count;
            res_in.vic_rank  = rd.rank;
         end
         if (!rd.valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = rd.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit        <= 1'b0;
         res_ff.vic_found  <= 1'b0;
         res_ff.free_found <= 1'b0;
      end else begin
         res_ff.hit        <= res_in.hit;
         res_ff.vic_found  <= res_in.vic_found;
         res_ff.free_found <= res_in.free_found;
      end
      res_ff.hit_idx   <= res_in.hit_idx;
      res_ff.hit_value <= res_in.hit_value;
      res_ff.hit_rank  <= res_in.hit_rank;
      res_ff.vic_idx   <= res_in.vic_idx;
      res_ff.vic_count <= res_in.vic_count;
      res_ff.vic_rank  <= res_in.vic_rank;
      res_ff.free_idx  <= res_in.free_idx;
   end

   assign res = res_ff;

endmodule

### rtl/lfu_ctrl.sv
// Sequencer: request capture, scan and update passes, occupancy, capacity and result word.
module lfu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [lfu_pkg::KEY_W-1:0]     req_lookup_key,
   input  logic [lfu_pkg::VAL_W-1:0]     req_write_value,
   input  logic                          csr_we,
   input  logic [lfu_pkg::CAP_W-1:0]     csr_wdata,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [lfu_pkg::VAL_W-1:0]     rsp_read_value,
   output logic                          scan_clr,
   output logic                          scan_en,
   output logic [lfu_pkg::KEY_W-1:0]     scan_key,
   input  lfu_pkg::scan_res_type         scan_res,
   output logic                          rd_en,
   output logic [lfu_pkg::IDX_W-1:0]     rd_idx,
   input  lfu_pkg::slot_rd_type          rd,
   output lfu_pkg::slot_wr_type          wr
);
   import lfu_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [CAP_W-1:0]      cap_ff;
   logic                  put_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VAL_W-1:0]      wval_ff;
   upd_mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]      tgt_ff, tgt_in;
   logic [IDX_W-1:0]      close_ff, close_in;
   logic [IDX_W-1:0]      new_rank_ff, new_rank_in;
   logic                  evict_ff, evict_in;
   logic [IDX_W-1:0]      vic_ff;
   logic                  strobe_ff;
   logic                  hit_ff;
   logic [VAL_W-1:0]      value_ff;

   logic                  accept;
   logic                  pass_done;
   logic [CAPE_W-1:0]     cap_wide, cap_eff;
   logic                  cap_zero;
   logic                  occ_full;
   logic                  do_evict;
   logic [IDX_W-1:0]      ins_idx;

   assign accept    = start && (state_ff == ST_IDLE);
   assign pass_done = (cnt_ff == CNT_W'(ENTRIES));
   assign scan_key  = key_ff;

   // Effective capacity, clamped to the slot count
   assign cap_wide = CAPE_W'(cap_ff);
   assign cap_eff  = (cap_wide > CAPE_W'(ENTRIES)) ? CAPE_W'(ENTRIES) : cap_wide;
   assign cap_zero = (cap_ff == '0);
   assign occ_full = (CAPE_W'(occ_ff) >= cap_eff);
   assign do_evict = occ_full && scan_res.vic_found;

   // Insert slot: first free slot after the eviction
   always_comb begin
      if (do_evict && !(scan_res.free_found && (scan_res.free_idx < scan_res.vic_idx))) begin
         ins_idx = scan_res.vic_idx;
      end else begin
         ins_idx = scan_res.free_idx;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (pass_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = (mode_in == UPD_NONE) ? ST_IDLE : ST_UPD;
         end
         ST_UPD: begin
            if (pass_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      busy     = 1'b1;
      scan_clr = 1'b0;
      scan_en  = 1'b0;
      rd_en    = 1'b0;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            scan_clr = accept;
            cnt_in   = '0;
         end
         ST_SCAN: begin
            scan_en = 1'b1;
            rd_en   = !pass_done;
            cnt_in  = pass_done ? '0 : cnt_ff + CNT_W'(1);
         end
         ST_RESP: begin
            cnt_in = '0;
         end
         ST_UPD: begin
            rd_en  = !pass_done;
            cnt_in = pass_done ? cnt_ff : cnt_ff + CNT_W'(1);
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   assign rd_idx = cnt_ff[IDX_W-1:0];

   // Decide the update pass from the scan findings
   always_comb begin
      mode_in     = UPD_NONE;
      tgt_in      = scan_res.hit_idx;
      close_in    = scan_res.hit_rank;
      new_rank_in = IDX_W'(occ_ff - OCC_W'(1));
      evict_in    = 1'b0;
      occ_in      = occ_ff;
      if (scan_res.hit) begin
         if (!(put_ff && cap_zero)) mode_in = UPD_TOUCH;
      end else if (put_ff && !cap_zero) begin
         mode_in  = UPD_INSERT;
         tgt_in   = ins_idx;
         close_in = scan_res.vic_rank;
         evict_in = do_evict;
         if (do_evict) begin
            new_rank_in = IDX_W'(occ_ff - OCC_W'(1));
         end else begin
            new_rank_in = IDX_W'(occ_ff);
            occ_in      = occ_ff + OCC_W'(1);
         end
      end
   end

   // Slot rewrite during the update pass
   always_comb begin
      wr.en    = (state_ff == ST_UPD) && rd.vld;
      wr.idx   = rd.idx;
      wr.valid = rd.valid;
      wr.key   = rd.key;
      wr.value = rd.value;
      wr.count = rd.count;
      wr.rank  = rd.rank;
      case (mode_ff)
         UPD_TOUCH: begin
            if (rd.idx == tgt_ff) begin
               wr.rank = new_rank_ff;
               if (rd.count != '1) wr.count = rd.count + COUNT_BITS'(1);
               if (put_ff) wr.value = wval_ff;
            end else if (rd.valid && (rd.rank > close_ff)) begin
               wr.rank = rd.rank - IDX_W'(1);
            end
         end
         UPD_INSERT: begin
            if (rd.idx == tgt_ff) begin
               wr.valid = 1'b1;
               wr.key   = key_ff;
               wr.value = wval_ff;
               wr.count = COUNT_BITS'(1);
               wr.rank  = new_rank_ff;
            end else if (evict_ff && (rd.idx == vic_ff)) begin
               wr.valid = 1'b0;
            end else if (evict_ff && rd.valid && (rd.rank > close_ff)) begin
               wr.rank = rd.rank - IDX_W'(1);
            end
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         occ_ff    <= '0;
         cap_ff    <= CAP_RESET;
         mode_ff   <= UPD_NONE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= (state_ff == ST_RESP);
         if (csr_we) cap_ff <= csr_wdata;
         if (state_ff == ST_RESP) begin
            occ_ff  <= occ_in;
            mode_ff <= mode_in;
         end
      end
   end

   // Request capture, update plan and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         put_ff  <= (req_type == REQ_PUT);
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
      end
      if (state_ff == ST_RESP) begin
         tgt_ff      <= tgt_in;
         close_ff    <= close_in;
         new_rank_ff <= new_rank_in;
         evict_ff    <= evict_in;
         vic_ff      <= scan_res.vic_idx;
         hit_ff      <= scan_res.hit;
         value_ff    <= scan_res.hit ? scan_res.hit_value : '0;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = value_ff;

endmodule

### rtl/lfu_cache_policy_unit.sv
// Top level of the LFU cache policy unit with recency tie-break.
// Start is taken only while idle. The result word is registered after the scan pass; busy
// spans an update pass too on a hit or an insert, save a put hit at zero capacity; the single
// read port of the slot store is swept once to scan and once to update.
// Results are shown for one cycle with rsp_strobe; the receiver cannot stall.
// Synchronous reset empties the store, zeroes occupancy and sets capacity to 16.
module lfu_cache_policy_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_lookup_key,
   input  logic [31:0] req_write_value,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_value
);
   import lfu_pkg::*;

   slot_rd_type      rd;
   slot_wr_type      wr;
   scan_res_type     scan_res;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   logic             scan_clr;
   logic             scan_en;
   logic [KEY_W-1:0] scan_key;

   lfu_slot_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_idx (rd_idx),
      .wr     (wr),
      .rd     (rd)
   );

   lfu_scan_unit u_scan (
      .clock (clock),
      .reset (reset),
      .clr   (scan_clr),
      .en    (scan_en),
      .key   (scan_key),
      .rd    (rd),
      .res   (scan_res)
   );

   lfu_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .scan_clr        (scan_clr),
      .scan_en         (scan_en),
      .scan_key        (scan_key),
      .scan_res        (scan_res),
      .rd_en           (rd_en),
      .rd_idx          (rd_idx),
      .rd              (rd),
      .wr              (wr)
   );

endmodule

### rtl/lfu_checker.sv
// Port-level checks for the LFU cache policy unit, bound to the top level.
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_value
);

   // Reset leaves the unit idle with no result word
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("unit not idle after reset");

   // A taken request keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after start");

   // A result word only follows a busy cycle, and never two in a row
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !$past(rsp_strobe)))
      else $error("result word without a request in progress");

   // A miss returns zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_read_value == 32'd0))
      else $error("miss with nonzero read value");

endmodule

bind lfu_cache_policy_unit lfu_checker u_lfu_checker (.*);
